[sv/two_class_weighted_service_queue_defines.svh]
// Assertion macros shared by the two-class weighted service queue.
// Depends on nothing; included by the modules that carry checks.
`ifndef TWO_CLASS_WEIGHTED_SERVICE_QUEUE_DEFINES_SVH
`define TWO_CLASS_WEIGHTED_SERVICE_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TCWSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TCWSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tcwsq_pkg.sv]
// Package for the two-class weighted service queue: sizes, codes and the
// command type that joins controller and datapath. Depends on nothing.
package tcwsq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int TAG_BITS    = 16;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int STORE_W     = (TAG_BITS < 16) ? TAG_BITS : 16;
	localparam int PHASE_W     = 2;

	localparam logic [7:0] THRESHOLD_RESET = 8'd60;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic capture;   // request accepted: decide, update FIFOs, start read
		logic load_out;  // move the finished result into the output register
	} dp_cmd_t;

endpackage

[sv/two_class_weighted_service_queue.sv]
// Top level of the two-class weighted service queue.
// Depends on tcwsq_pkg, tcwsq_ctrl and tcwsq_dp.
//
// Usage. Each request on the input channel (in_valid/in_ready) is either an
// enqueue (cmd low) of item_tag with its age, or a dequeue (cmd high). An
// enqueued tag goes to the high FIFO when age is at least the threshold, to
// the normal FIFO otherwise. A dequeue takes from the high FIFO when the
// service phase is zero and it holds items, else from the normal FIFO, else
// from the high FIFO; each served item steps the phase round four values.
// Every request gives exactly one result on the output channel
// (out_valid/out_ready): a status, the served tag and class, and both fill
// levels after the request. A full target FIFO drops the enqueue with a full
// status; a dequeue with both FIFOs empty gives an empty status.
// Timing. A request is taken in the idle state; in the response state, once
// the output register is free or being read, the result is loaded into it
// after the registered store read and out_valid rises. No new request is
// taken before that. If the receiver stalls, the result waits there and a
// following request is still accepted and waits for it. Reset empties both
// FIFOs, zeroes the phase and sets the threshold to 60, written via cfg_we
// and cfg_wdata by the user only while idle; the block does not enforce it.
module two_class_weighted_service_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] item_tag,
	input  logic [7:0]  age,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] served_tag,
	output logic        served_high,
	output logic [7:0]  high_waiting,
	output logic [7:0]  normal_waiting
);
	import tcwsq_pkg::*;

	dp_cmd_t dp_cmd;

	tcwsq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd)
	);

	tcwsq_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.cmd            (cmd),
		.item_tag       (item_tag),
		.age            (age),
		.status         (status),
		.served_tag     (served_tag),
		.served_high    (served_high),
		.high_waiting   (high_waiting),
		.normal_waiting (normal_waiting)
	);

endmodule

[sv/tcwsq_ctrl.sv]
// Controller of the two-class weighted service queue: request handshake,
// result handshake and sequencing. Depends on tcwsq_pkg and the defines header.
`include "two_class_weighted_service_queue_defines.svh"

module tcwsq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output tcwsq_pkg::dp_cmd_t dp_cmd
);
	import tcwsq_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic state_q;
	logic out_valid_q;

	always_comb begin
		in_ready         = (state_q == S_IDLE);
		dp_cmd.capture   = in_valid && (state_q == S_IDLE);
		dp_cmd.load_out  = (state_q == S_RESP) && (!out_valid_q || out_ready);
		out_valid        = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (dp_cmd.capture) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (dp_cmd.load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (dp_cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`TCWSQ_ASSERT_NEXT(a_accept_blocks, clk, arst_n, in_valid && in_ready, !in_ready,
		"second request taken while one is in flight")
	`TCWSQ_ASSERT_NEXT(a_load_shows, clk, arst_n, dp_cmd.load_out,
		out_valid && (state_q == S_IDLE), "loaded result not presented")

endmodule

[sv/tcwsq_dp.sv]
// Datapath of the two-class weighted service queue: the two FIFO stores,
// their pointers and counts, service phase, threshold and output register.
// Depends on tcwsq_pkg and the defines header.
`include "two_class_weighted_service_queue_defines.svh"

module tcwsq_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  tcwsq_pkg::dp_cmd_t dp_cmd,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               cmd,
	input  logic [15:0]        item_tag,
	input  logic [7:0]         age,
	output logic [1:0]         status,
	output logic [15:0]        served_tag,
	output logic               served_high,
	output logic [7:0]         high_waiting,
	output logic [7:0]         normal_waiting
);
	import tcwsq_pkg::*;

	logic [STORE_W-1:0] high_mem   [QUEUE_DEPTH];
	logic [STORE_W-1:0] normal_mem [QUEUE_DEPTH];

	logic [7:0]         threshold_q;
	logic [PTR_W-1:0]   high_head_q, high_tail_q, normal_head_q, normal_tail_q;
	logic [CNT_W-1:0]   high_count_q, normal_count_q;
	logic [PHASE_W-1:0] phase_q;

	logic [STORE_W-1:0] high_rd_q, normal_rd_q;
	logic [1:0]         res_status_q;
	logic               res_high_q;
	logic               res_served_q;

	logic [1:0]  status_q;
	logic [15:0] served_tag_q;
	logic        served_high_q;
	logic [7:0]  high_waiting_q, normal_waiting_q;

	logic high_full, normal_full, high_any, normal_any;
	logic to_high, take_high, take_normal;
	logic push_high, push_normal, pop_high, pop_normal;
	logic [1:0] status_nxt;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		high_full   = (high_count_q == CNT_W'(QUEUE_DEPTH));
		normal_full = (normal_count_q == CNT_W'(QUEUE_DEPTH));
		high_any    = (high_count_q != '0);
		normal_any  = (normal_count_q != '0);
		to_high     = (age >= threshold_q);
		// High is forced ahead on phase zero, otherwise it only fills in.
		take_high   = ((phase_q == '0) && high_any) || (!normal_any && high_any);
		take_normal = !take_high && normal_any;

		push_high   = dp_cmd.capture && (cmd == CMD_ENQ) && to_high && !high_full;
		push_normal = dp_cmd.capture && (cmd == CMD_ENQ) && !to_high && !normal_full;
		pop_high    = dp_cmd.capture && (cmd == CMD_DEQ) && take_high;
		pop_normal  = dp_cmd.capture && (cmd == CMD_DEQ) && take_normal;

		if (cmd == CMD_ENQ) begin
			status_nxt = (to_high ? high_full : normal_full) ? ST_FULL : ST_OK;
		end else begin
			status_nxt = (take_high || take_normal) ? ST_OK : ST_EMPTY;
		end
	end

	always_ff @(posedge clk) begin
		if (push_high) begin
			high_mem[high_tail_q] <= item_tag[STORE_W-1:0];
		end
		if (pop_high) begin
			high_rd_q <= high_mem[high_head_q];
		end
	end

	always_ff @(posedge clk) begin
		if (push_normal) begin
			normal_mem[normal_tail_q] <= item_tag[STORE_W-1:0];
		end
		if (pop_normal) begin
			normal_rd_q <= normal_mem[normal_head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q    <= THRESHOLD_RESET;
			high_head_q    <= '0;
			high_tail_q    <= '0;
			high_count_q   <= '0;
			normal_head_q  <= '0;
			normal_tail_q  <= '0;
			normal_count_q <= '0;
			phase_q        <= '0;
		end else begin
			if (cfg_we) begin
				threshold_q <= cfg_wdata;
			end
			if (push_high) begin
				high_tail_q  <= ptr_next(high_tail_q);
				high_count_q <= high_count_q + 1'b1;
			end
			if (pop_high) begin
				high_head_q  <= ptr_next(high_head_q);
				high_count_q <= high_count_q - 1'b1;
			end
			if (push_normal) begin
				normal_tail_q  <= ptr_next(normal_tail_q);
				normal_count_q <= normal_count_q + 1'b1;
			end
			if (pop_normal) begin
				normal_head_q  <= ptr_next(normal_head_q);
				normal_count_q <= normal_count_q - 1'b1;
			end
			if (pop_high || pop_normal) begin
				phase_q <= phase_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.capture) begin
			res_status_q <= status_nxt;
			res_high_q   <= pop_high;
			res_served_q <= pop_high || pop_normal;
		end
		if (dp_cmd.load_out) begin
			status_q         <= res_status_q;
			served_high_q    <= res_high_q;
			served_tag_q     <= !res_served_q ? 16'd0 :
			                    res_high_q ? 16'(high_rd_q) : 16'(normal_rd_q);
			high_waiting_q   <= 8'(high_count_q);
			normal_waiting_q <= 8'(normal_count_q);
		end
	end

	assign status         = status_q;
	assign served_tag     = served_tag_q;
	assign served_high    = served_high_q;
	assign high_waiting   = high_waiting_q;
	assign normal_waiting = normal_waiting_q;

	`TCWSQ_ASSERT_NOW(a_counts_bounded, clk, arst_n, 1'b1,
		(high_count_q <= CNT_W'(QUEUE_DEPTH)) && (normal_count_q <= CNT_W'(QUEUE_DEPTH)),
		"FIFO count beyond depth")
	`TCWSQ_ASSERT_NEXT(a_phase_on_pop, clk, arst_n, pop_high || pop_normal,
		phase_q == $past(phase_q) + 1'b1, "phase did not advance on service")

endmodule
